### src/cll_pkg.sv
package cll_pkg;

  // Number of node slots in the store.
  localparam int CAPACITY = 64;
  localparam int IDX_W = $clog2(CAPACITY);

  // Field widths fixed by the interface.
  localparam int SYM_W = 8;
  localparam int LINK_W = 7;
  localparam int POS_W = 7;

  // Any link at or above the capacity is the null link.
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] WALK_LAST = POS_W'(CAPACITY - 1);

  typedef enum logic [3:0] {
    OP_CLEAR  = 4'd0,
    OP_HEAD   = 4'd1,
    OP_MOVE   = 4'd2,
    OP_READ   = 4'd3,
    OP_DELETE = 4'd4,
    OP_CUT    = 4'd5,
    OP_EDIT   = 4'd6,
    OP_INSERT = 4'd7,
    OP_DUMP   = 4'd8,
    OP_STATUS = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_END   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_INS2,
    S_DUMP
  } state_t;

  // True when the link names a real slot.
  function automatic logic link_ok(input logic [LINK_W-1:0] l);
    return l < NULL_LINK;
  endfunction

endpackage

### src/cursor_linked_list_engine.sv
// Channel     | Ports                                         | Direction
// ------------+-----------------------------------------------+----------
// command     | start, busy (out), in_operation, in_symbol_in | in
// result      | out_valid, out_symbol_out, out_status,        | out
//             | out_list_empty, out_cursor_at_end,            |
//             | out_position, out_last                        |
//
// In a command transaction the accept cycle issues the node memory read,
// and the next cycle does the update and registers the result.
// An insert behind an existing cursor does the second link write in a further
// state, S_INS2, since the link memory has a single write port.
// A dump streams one result per node per cycle after the first read.
// Synchronous active-low reset empties the list; node memories are not cleared.
// Results are strobed for one cycle each; the receiver cannot stall them.
module cursor_linked_list_engine
  import cll_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [3:0]        in_operation,
  input  logic [SYM_W-1:0]  in_symbol_in,
  output logic              out_valid,
  output logic [SYM_W-1:0]  out_symbol_out,
  output logic [1:0]        out_status,
  output logic              out_list_empty,
  output logic              out_cursor_at_end,
  output logic [POS_W-1:0]  out_position,
  output logic              out_last
);

  // Node store: symbol and link memories, one write and one registered read each.
  logic [SYM_W-1:0]  sym_mem [CAPACITY];
  logic [LINK_W-1:0] link_mem [CAPACITY];

  state_t state_r, state_nxt;
  op_t    op_r;
  logic [SYM_W-1:0] sym_r;

  logic [LINK_W-1:0] head_r, head_nxt;
  logic [LINK_W-1:0] cur_r, cur_nxt;
  // Cached successor link of the cursor node, so flags never need a read.
  logic [LINK_W-1:0] cur_link_r, cur_link_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CAPACITY-1:0] used_r, used_nxt;
  logic [POS_W-1:0]  cnt_r, cnt_nxt;

  // Lowest free slot, found in the accept cycle and registered.
  logic             free_ok;
  logic [IDX_W-1:0] free_idx;
  logic             free_ok_r;
  logic [IDX_W-1:0] free_idx_r;

  logic [IDX_W-1:0]  rd_addr;
  logic [SYM_W-1:0]  rd_sym_r;
  logic [LINK_W-1:0] rd_link_r;

  logic              sym_we, link_we;
  logic [IDX_W-1:0]  sym_wa, link_wa;
  logic [SYM_W-1:0]  sym_wd;
  logic [LINK_W-1:0] link_wd;

  logic              accept;
  logic              list_empty;
  logic              walk_last;
  status_t           next_chk;

  logic              res_valid;
  logic [SYM_W-1:0]  res_sym;
  status_t           res_status;
  logic              res_last;
  logic              res_empty;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign list_empty = !link_ok(head_r);
  // A dump ends at the null link or after a full store's worth of nodes.
  assign walk_last = !link_ok(rd_link_r) || (cnt_r == WALK_LAST);

  always_comb begin
    if (list_empty || !link_ok(cur_r)) begin
      next_chk = ST_EMPTY;
    end else if (!link_ok(cur_link_r)) begin
      next_chk = ST_END;
    end else begin
      next_chk = ST_OK;
    end
  end

  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_ok  = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // The accept cycle reads the head node or the cursor's successor; a dump
  // then follows the link it just read.
  always_comb begin
    if (state_r == S_IDLE) begin
      if (op_t'(in_operation) == OP_HEAD || op_t'(in_operation) == OP_DUMP) begin
        rd_addr = head_r[IDX_W-1:0];
      end else begin
        rd_addr = cur_link_r[IDX_W-1:0];
      end
    end else begin
      rd_addr = rd_link_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (sym_we) begin
      sym_mem[sym_wa] <= sym_wd;
    end
    rd_sym_r <= sym_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    rd_link_r <= link_mem[rd_addr];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (op_r == OP_INSERT && free_ok_r && !list_empty && link_ok(cur_r)) begin
          state_nxt = S_INS2;
        end else if (op_r == OP_DUMP && !list_empty && !walk_last) begin
          state_nxt = S_DUMP;
        end
      end
      S_INS2: begin
        state_nxt = S_IDLE;
      end
      S_DUMP: begin
        if (walk_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath, memory writes and results.
  always_comb begin
    head_nxt     = head_r;
    cur_nxt      = cur_r;
    cur_link_nxt = cur_link_r;
    pos_nxt      = pos_r;
    used_nxt     = used_r;
    cnt_nxt      = cnt_r;
    sym_we       = 1'b0;
    sym_wa       = cur_link_r[IDX_W-1:0];
    sym_wd       = sym_r;
    link_we      = 1'b0;
    link_wa      = cur_r[IDX_W-1:0];
    link_wd      = rd_link_r;
    res_valid    = 1'b0;
    res_sym      = '0;
    res_status   = ST_OK;
    res_last     = 1'b1;

    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
      end
      S_EXEC: begin
        res_valid = 1'b1;
        case (op_r)
          OP_CLEAR: begin
            used_nxt     = '0;
            head_nxt     = NULL_LINK;
            cur_nxt      = NULL_LINK;
            cur_link_nxt = NULL_LINK;
            pos_nxt      = '0;
          end
          OP_HEAD: begin
            if (list_empty) begin
              res_status = ST_EMPTY;
            end else begin
              cur_nxt      = head_r;
              cur_link_nxt = rd_link_r;
              pos_nxt      = POS_W'(1);
            end
          end
          OP_MOVE, OP_READ, OP_DELETE, OP_CUT, OP_EDIT: begin
            if (next_chk != ST_OK) begin
              res_status = next_chk;
            end else if (op_r == OP_MOVE) begin
              cur_nxt      = cur_link_r;
              cur_link_nxt = rd_link_r;
              pos_nxt      = (pos_r == POS_MAX) ? pos_r : pos_r + POS_W'(1);
            end else if (op_r == OP_EDIT) begin
              sym_we = 1'b1;
            end else if (op_r == OP_READ) begin
              res_sym = rd_sym_r;
            end else begin
              // Delete and cut unlink the successor and free its slot.
              link_we      = 1'b1;
              cur_link_nxt = rd_link_r;
              used_nxt[cur_link_r[IDX_W-1:0]] = 1'b0;
              if (op_r == OP_CUT) begin
                res_sym = rd_sym_r;
              end
            end
          end
          OP_INSERT: begin
            if (!free_ok_r) begin
              res_status = ST_FULL;
            end else begin
              used_nxt[free_idx_r] = 1'b1;
              sym_we  = 1'b1;
              sym_wa  = free_idx_r;
              link_we = 1'b1;
              link_wa = free_idx_r;
              if (list_empty || !link_ok(cur_r)) begin
                link_wd      = NULL_LINK;
                head_nxt     = LINK_W'(free_idx_r);
                cur_nxt      = LINK_W'(free_idx_r);
                cur_link_nxt = NULL_LINK;
                pos_nxt      = POS_W'(1);
              end else begin
                // The cursor's own link is rewritten in the following cycle.
                link_wd      = cur_link_r;
                cur_link_nxt = LINK_W'(free_idx_r);
              end
            end
          end
          OP_DUMP: begin
            if (list_empty) begin
              res_status = ST_EMPTY;
            end else begin
              res_sym  = rd_sym_r;
              res_last = walk_last;
              cnt_nxt  = cnt_r + POS_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
      S_INS2: begin
        link_we = 1'b1;
        link_wa = cur_r[IDX_W-1:0];
        link_wd = LINK_W'(free_idx_r);
      end
      S_DUMP: begin
        res_valid = 1'b1;
        res_sym   = rd_sym_r;
        res_last  = walk_last;
        cnt_nxt   = cnt_r + POS_W'(1);
      end
      default: begin
      end
    endcase

    res_empty = !link_ok(head_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= NULL_LINK;
      cur_r      <= NULL_LINK;
      cur_link_r <= NULL_LINK;
      pos_r      <= '0;
      used_r     <= '0;
      cnt_r      <= '0;
      out_valid  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      cur_r      <= cur_nxt;
      cur_link_r <= cur_link_nxt;
      pos_r      <= pos_nxt;
      used_r     <= used_nxt;
      cnt_r      <= cnt_nxt;
      out_valid  <= res_valid;
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= op_t'(in_operation);
      sym_r      <= in_symbol_in;
      free_ok_r  <= free_ok;
      free_idx_r <= free_idx;
    end
    if (res_valid) begin
      out_symbol_out    <= res_sym;
      out_status        <= res_status;
      out_last          <= res_last;
      out_list_empty    <= res_empty;
      out_cursor_at_end <= !res_empty && link_ok(cur_nxt) && !link_ok(cur_link_nxt);
      out_position      <= res_empty ? '0 : pos_nxt;
    end
  end

endmodule
